### hw/rtl/dtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal text to float unit
// Word formats, controller states, command and status bundles, and the
// character and single-precision constants used by the parser.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int MAX_DIGITS_DEF = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Single-precision scale factors 0.01f, 0.1f and 10.0f.
    localparam logic [31:0] F_HUNDREDTH = 32'h3C23_D70A;
    localparam logic [31:0] F_TENTH     = 32'h3DCC_CCCD;
    localparam logic [31:0] F_TEN       = 32'h4120_0000;

    // Biased exponent of a 32-bit integer whose top bit is set.
    localparam logic [7:0] NORM_EXP_TOP = 8'd158;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        ok;
        logic [7:0]  used_chars;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_NORM,
        ST_CONV,
        ST_SCALE,
        ST_MUL,
        ST_RND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic norm_shift;
        logic conv;
        logic mul;
        logic rnd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic term;
        logic zero;
        logic norm_done;
        logic exp_nonzero;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/decimal_text_to_float_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_float_unit: streaming ASCII decimal to single-precision
// Parses a signed decimal number one character word at a time and delivers
// its IEEE-754 single bit pattern, a digit-seen flag and the character count.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Word
//   -------  --------------------  ------------------------------------------
//   in       in_valid / in_ready   in_word: ch, first
//   out      out_valid / out_ready out_word: value_bits, ok, used_chars
//
// Sign, digit and point words are taken one per cycle. A terminating word
// starts the finishing sequence: one-bit normalize shifts until the top bit
// is set (a zero integer skips straight to the output load), a conversion,
// then for every scale step of the shared single-precision multiplier an
// issue, multiply and round state, plus one closing scale check, with up to
// 127 steps for large exponents. The output register is then loaded, which
// waits until the previous word has left; the input is stalled through all
// of this. The result then waits in the output register while the next
// number is parsed. Reset is asynchronous and leaves the unit idle and empty.
//
module decimal_text_to_float_unit #(
    parameter int MAX_DIGITS = dtf_pkg::MAX_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtf_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output dtf_pkg::out_word_t out_word
);
    import dtf_pkg::*;

    // Commands from the controller and status from the datapath.
    cmd_t cmd;
    sts_t sts;

    dtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // The datapath parses accepted words and holds the result register.
    dtf_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .out_ready (out_ready),
        .sts       (sts),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

`ifndef ASSERT_OFF
    a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.ok) |-> (out_word.value_bits == 32'd0))
        else $error("word without digits carries a nonzero value");
    a_term_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.term) |=> !in_ready)
        else $error("input not stalled after a terminator");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

### hw/rtl/dtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_ctrl: sequencing controller
// Steps a finished number through normalize, convert, scale and hand-off.
// ----------------------------------------------------------------------------
module dtf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  dtf_pkg::sts_t sts,
    output logic          in_ready,
    output dtf_pkg::cmd_t cmd
);
    import dtf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_valid && sts.term)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (sts.zero)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.norm_done)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:  state_next = ST_SCALE;
            ST_SCALE: state_next = sts.exp_nonzero ? ST_MUL : ST_DONE;
            ST_MUL:   state_next = ST_RND;
            ST_RND:   state_next = ST_SCALE;
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_RUN;
                end
            end
            default:  state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_NORM:  cmd.norm_shift = !sts.zero && !sts.norm_done;
            ST_CONV:  cmd.conv = 1'b1;
            ST_SCALE: cmd.mul = sts.exp_nonzero;
            ST_MUL:   cmd.rnd = 1'b0;
            ST_RND:   cmd.rnd = 1'b1;
            ST_DONE:  cmd.out_load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_conv_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> sts.norm_done)
        else $error("conversion started on an unnormalized integer");
    a_mul_then_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_RND))
        else $error("product not rounded after multiply");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending word");
`endif

endmodule

### hw/rtl/dtf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtf_datapath: character parser, integer-to-float and float multiplier
// Holds the parse state, the float working value and the output register.
// ----------------------------------------------------------------------------
module dtf_datapath #(
    parameter int MAX_DIGITS = dtf_pkg::MAX_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dtf_pkg::in_word_t  in_word,
    input  dtf_pkg::cmd_t      cmd,
    input  logic               out_ready,
    output dtf_pkg::sts_t      sts,
    output logic               out_valid,
    output dtf_pkg::out_word_t out_word
);
    import dtf_pkg::*;

    localparam int ACC_W = $clog2(10 ** MAX_DIGITS);

    // Parse state.
    logic             active_reg;
    logic             neg_reg;
    logic             frac_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [7:0] dexp_reg;
    logic [7:0]       dcnt_reg;
    logic [7:0]       ccnt_reg;

    logic             active_next;
    logic             neg_next;
    logic             frac_next;
    logic [ACC_W-1:0] acc_next;
    logic signed [7:0] dexp_next;
    logic [7:0]       dcnt_next;
    logic [7:0]       ccnt_next;

    // Finishing state.
    logic             fin_neg_reg;
    logic             fin_ok_reg;
    logic [7:0]       fin_used_reg;
    logic [31:0]      n_reg;
    logic [7:0]       nexp_reg;
    logic signed [7:0] e_reg;
    logic [31:0]      f_reg;
    logic [47:0]      prod_reg;
    logic [9:0]       esum_reg;
    logic             ainf_reg;

    logic             out_valid_reg;
    out_word_t        out_word_reg;

    // Parse combinational.
    logic             cur_neg, cur_frac, act;
    logic [ACC_W-1:0] cur_acc;
    logic signed [7:0] cur_dexp;
    logic [7:0]       cur_dcnt, cur_ccnt, d, dcnt_inc;
    logic             is_sign, is_dig, is_dot, term;
    logic [ACC_W+3:0] acc_x10;

    always_comb
    begin
        cur_neg  = in_word.first ? 1'b0 : neg_reg;
        cur_frac = in_word.first ? 1'b0 : frac_reg;
        cur_acc  = in_word.first ? '0 : acc_reg;
        cur_dexp = in_word.first ? 8'sd0 : dexp_reg;
        cur_dcnt = in_word.first ? 8'd0 : dcnt_reg;
        cur_ccnt = in_word.first ? 8'd0 : ccnt_reg;
        act      = in_word.first || active_reg;
        d        = in_word.ch - CH_ZERO;
        is_sign  = (cur_ccnt == 8'd0) && ((in_word.ch == CH_MINUS) || (in_word.ch == CH_PLUS));
        is_dig   = !is_sign && (d <= 8'd9);
        is_dot   = !is_sign && !is_dig && (in_word.ch == CH_POINT) && !cur_frac;
        term     = act && !is_sign && !is_dig && !is_dot;
        dcnt_inc = (cur_dcnt == 8'd255) ? cur_dcnt : cur_dcnt + 8'd1;
        acc_x10  = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
                 + (ACC_W+4)'(d[3:0]);
    end

    always_comb
    begin
        active_next = active_reg;
        neg_next    = neg_reg;
        frac_next   = frac_reg;
        acc_next    = acc_reg;
        dexp_next   = dexp_reg;
        dcnt_next   = dcnt_reg;
        ccnt_next   = ccnt_reg;
        if (cmd.accept && act)
        begin
            active_next = !term;
            neg_next    = cur_neg;
            frac_next   = cur_frac;
            acc_next    = cur_acc;
            dexp_next   = cur_dexp;
            dcnt_next   = cur_dcnt;
            ccnt_next   = (term || cur_ccnt == 8'd255) ? cur_ccnt : cur_ccnt + 8'd1;
            if (is_sign)
            begin
                neg_next = (in_word.ch == CH_MINUS);
            end
            else if (is_dig)
            begin
                dcnt_next = dcnt_inc;
                if (dcnt_inc <= 8'(MAX_DIGITS))
                begin
                    acc_next = acc_x10[ACC_W-1:0];
                    if (cur_frac)
                    begin
                        dexp_next = cur_dexp - 8'sd1;
                    end
                end
                else if (!cur_frac && cur_dexp < 8'sd127)
                begin
                    dexp_next = cur_dexp + 8'sd1;
                end
            end
            else if (is_dot)
            begin
                frac_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            neg_reg    <= 1'b0;
            frac_reg   <= 1'b0;
            acc_reg    <= '0;
            dexp_reg   <= 8'sd0;
            dcnt_reg   <= 8'd0;
            ccnt_reg   <= 8'd0;
        end
        else
        begin
            active_reg <= active_next;
            neg_reg    <= neg_next;
            frac_reg   <= frac_next;
            acc_reg    <= acc_next;
            dexp_reg   <= dexp_next;
            dcnt_reg   <= dcnt_next;
            ccnt_reg   <= ccnt_next;
        end
    end

    // Conversion rounding of the normalized integer.
    logic        cv_up;
    logic [24:0] cv_sum;
    logic [31:0] cv_float;

    always_comb
    begin
        cv_up  = n_reg[7] && ((|n_reg[6:0]) || n_reg[8]);
        cv_sum = {1'b0, n_reg[31:8]} + 25'(cv_up);
        if (cv_sum[24])
        begin
            cv_float = {1'b0, nexp_reg + 8'd1, 23'd0};
        end
        else
        begin
            cv_float = {1'b0, nexp_reg, cv_sum[22:0]};
        end
    end

    // Scale factor choice and exponent step.
    logic [31:0]       k_float;
    logic signed [7:0] e_step;

    always_comb
    begin
        if (e_reg <= -8'sd2)
        begin
            k_float = F_HUNDREDTH;
            e_step  = e_reg + 8'sd2;
        end
        else if (e_reg < 8'sd0)
        begin
            k_float = F_TENTH;
            e_step  = 8'sd0;
        end
        else
        begin
            k_float = F_TEN;
            e_step  = e_reg - 8'sd1;
        end
    end

    // Product rounding.
    logic        rn_hi, rn_g, rn_s, rn_up;
    logic [23:0] rn_m;
    logic [24:0] rn_sum;
    logic [10:0] rn_exp;
    logic [31:0] rn_float;

    always_comb
    begin
        rn_hi = prod_reg[47];
        if (rn_hi)
        begin
            rn_m = prod_reg[47:24];
            rn_g = prod_reg[23];
            rn_s = |prod_reg[22:0];
        end
        else
        begin
            rn_m = prod_reg[46:23];
            rn_g = prod_reg[22];
            rn_s = |prod_reg[21:0];
        end
        rn_up  = rn_g && (rn_s || rn_m[0]);
        rn_sum = {1'b0, rn_m} + 25'(rn_up);
        rn_exp = {1'b0, esum_reg} + 11'(rn_hi) + 11'(rn_sum[24]) - 11'd127;
        if (ainf_reg || rn_exp >= 11'd255)
        begin
            rn_float = {1'b0, 8'hFF, 23'd0};
        end
        else
        begin
            rn_float = {1'b0, rn_exp[7:0], rn_sum[24] ? 23'd0 : rn_sum[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && term)
        begin
            fin_neg_reg  <= cur_neg;
            fin_ok_reg   <= (cur_dcnt != 8'd0);
            fin_used_reg <= cur_ccnt;
            n_reg        <= {{(32-ACC_W){1'b0}}, cur_acc};
            nexp_reg     <= NORM_EXP_TOP;
            e_reg        <= cur_dexp;
            f_reg        <= 32'd0;
        end
        if (cmd.norm_shift)
        begin
            n_reg    <= {n_reg[30:0], 1'b0};
            nexp_reg <= nexp_reg - 8'd1;
        end
        if (cmd.conv)
        begin
            f_reg <= cv_float;
        end
        if (cmd.mul)
        begin
            prod_reg <= {1'b1, f_reg[22:0]} * {1'b1, k_float[22:0]};
            esum_reg <= {2'b00, f_reg[30:23]} + {2'b00, k_float[30:23]};
            ainf_reg <= (f_reg[30:23] == 8'hFF);
            e_reg    <= e_step;
        end
        if (cmd.rnd)
        begin
            f_reg <= rn_float;
        end
        if (cmd.out_load)
        begin
            out_word_reg.value_bits <= fin_ok_reg ? {fin_neg_reg, f_reg[30:0]} : 32'd0;
            out_word_reg.ok         <= fin_ok_reg;
            out_word_reg.used_chars <= fin_used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.term        = term;
        sts.zero        = (n_reg == 32'd0);
        sts.norm_done   = n_reg[31];
        sts.exp_nonzero = (e_reg != 8'sd0);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### verif/decimal_text_to_float_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_float_unit_tb: self-checking bench for the text to float unit
// Streams directed and random character words through the unit under random
// idling on both channels. A scoreboard parses the same words with its own
// bit-exact single-precision conversion and multiplies, then checks every
// result word in order.
// ----------------------------------------------------------------------------
module decimal_text_to_float_unit_tb;
    import dtf_pkg::*;

    // The scoreboard keeps its own copy of the parser state. Each accepted
    // character word advances it, and a terminating word queues the value,
    // the digit flag and the character count that the unit must deliver.
    class float_parse_scoreboard;
        bit          active;
        bit          negative;
        bit          in_fraction;
        logic [31:0] mantissa_acc;
        int          dec_exponent;
        int          digit_count;
        int          char_count;
        out_word_t   expected_words[$];
        int          errors;

        function new();
            active = 0;
            errors = 0;
            clear_number();
        endfunction

        function void clear_number();
            negative = 0;
            in_fraction = 0;
            mantissa_acc = '0;
            dec_exponent = 0;
            digit_count = 0;
            char_count = 0;
        endfunction

        // Unsigned integer to single precision, round to nearest even.
        function logic [31:0] int_to_single(logic [31:0] m);
            int          k;
            int          sh;
            logic [63:0] frac;
            logic [63:0] rem;
            logic [63:0] half;
            if (m == 0)
                return 32'h0;
            k = 31;
            while (!m[k])
                k--;
            if (k <= 23) begin
                frac = 64'(m) << (23 - k);
            end else begin
                sh = k - 23;
                frac = 64'(m) >> sh;
                rem = 64'(m) & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && frac[0]))
                    frac++;
                if (frac[24]) begin
                    frac = frac >> 1;
                    k++;
                end
            end
            return {1'b0, 8'(127 + k), frac[22:0]};
        endfunction

        // Single-precision multiply of a positive normal or infinite value by
        // a positive normal constant, round to nearest even, overflow to inf.
        function logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
            logic [47:0] prod;
            logic [24:0] frac;
            logic [23:0] rest;
            int          e;
            if (a[30:23] == 8'hFF)
                return a;
            prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
            e = int'(a[30:23]) + int'(b[30:23]) - 127;
            if (prod[47])
                e++;
            else
                prod = prod << 1;
            frac = {1'b0, prod[47:24]};
            rest = prod[23:0];
            if (rest > 24'h80_0000 || (rest == 24'h80_0000 && frac[0]))
                frac++;
            if (frac[24]) begin
                frac = frac >> 1;
                e++;
            end
            if (e >= 255)
                return 32'h7F80_0000;
            return {1'b0, 8'(e), frac[22:0]};
        endfunction

        function logic [31:0] scaled_value();
            logic [31:0] v;
            int          e;
            v = int_to_single(mantissa_acc);
            e = dec_exponent;
            if (mantissa_acc != 0) begin
                while (e <= -2) begin
                    v = single_mul(v, F_HUNDREDTH);
                    e += 2;
                end
                if (e < 0) begin
                    v = single_mul(v, F_TENTH);
                end else begin
                    while (e > 0) begin
                        v = single_mul(v, F_TEN);
                        e--;
                    end
                end
            end
            if (negative)
                v[31] = ~v[31];
            return v;
        endfunction

        function void note_char(in_word_t w);
            out_word_t r;
            logic [7:0] d;
            if (w.first) begin
                clear_number();
                active = 1;
            end
            if (!active)
                return;
            d = w.ch - CH_ZERO;
            if (char_count == 0 && (w.ch == CH_MINUS || w.ch == CH_PLUS)) begin
                negative = (w.ch == CH_MINUS);
            end else if (d <= 9) begin
                if (digit_count < 255)
                    digit_count++;
                if (digit_count <= MAX_DIGITS_DEF) begin
                    if (in_fraction)
                        dec_exponent--;
                    mantissa_acc = mantissa_acc * 10 + d;
                end else if (!in_fraction) begin
                    if (dec_exponent < 127)
                        dec_exponent++;
                end
            end else if (w.ch == CH_POINT && !in_fraction) begin
                in_fraction = 1;
            end else begin
                r.ok = (digit_count != 0);
                r.value_bits = r.ok ? scaled_value() : 32'h0;
                r.used_chars = 8'(char_count);
                expected_words.push_back(r);
                active = 0;
                return;
            end
            if (char_count < 255)
                char_count++;
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.value_bits !== want.value_bits) begin
                $display("%0t: value_bits expected %h actual %h", $time,
                         want.value_bits, got.value_bits);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
                errors++;
            end
            if (got.used_chars !== want.used_chars) begin
                $display("%0t: used_chars expected %0d actual %0d", $time,
                         want.used_chars, got.used_chars);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    float_parse_scoreboard parse_sb;
    in_word_t              text_words[$];
    bit                    sending_done;

    decimal_text_to_float_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Append one number: the first word carries the start flag. A terminator
    // of -1 adds no terminator word, so the number is left open for a restart.
    task automatic add_text(string s, int term);
        in_word_t w;
        for (int i = 0; i < s.len(); i++) begin
            w.ch = s[i];
            w.first = (i == 0);
            text_words.push_back(w);
        end
        if (term >= 0) begin
            w.ch = 8'(term);
            w.first = (s.len() == 0);
            text_words.push_back(w);
        end
    endtask

    function automatic string random_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    // Well-formed numbers with random content make up most of the stream,
    // so the scaling loop sees a wide spread of mantissas and exponents.
    task automatic add_random_number();
        string s;
        int    nint;
        int    pick;
        int    term;
        s = "";
        pick = $urandom_range(0, 5);
        if (pick == 0)
            s = "-";
        else if (pick == 1)
            s = "+";
        nint = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 140)
                                             : $urandom_range(0, 10);
        s = {s, random_digits(nint)};
        if ($urandom_range(0, 1)) begin
            s = {s, "."};
            s = {s, random_digits($urandom_range(0, 11))};
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: term = 0;
            3:       term = " ";
            4:       term = CH_POINT;
            5:       term = ($urandom_range(0, 1)) ? CH_MINUS : CH_PLUS;
            6:       term = -1;
            default: term = $urandom_range(0, 255);
        endcase
        add_text(s, term);
    endtask

    // Noise: random bytes with random start flags, mostly ignored or
    // ending a number at once.
    task automatic add_noise();
        in_word_t w;
        repeat ($urandom_range(1, 6)) begin
            w.ch = 8'($urandom_range(0, 255));
            w.first = ($urandom_range(0, 3) == 0);
            text_words.push_back(w);
        end
    endtask

    task automatic build_stimulus();
        in_word_t w;
        // Directed part: extremes, signs, points, restart and saturation.
        add_text("0", 0);
        add_text("-0", 0);
        add_text("+", 0);
        add_text("", 0);
        add_text("-", " ");
        add_text("99999999", 0);
        add_text("123456789", 0);
        add_text("0.00000001", 0);
        add_text("-.5", 0);
        add_text("1.2", CH_POINT);
        add_text("12", CH_MINUS);
        add_text("7", 8'hFF);
        add_text({"3", random_digits(45)}, 0);
        add_text({"9", random_digits(140)}, 0);
        add_text("1.99999999999", 0);
        add_text(random_digits(300), 0);
        add_text("456", -1);
        add_text("-8.25", 0);
        w.ch = "5";
        w.first = 0;
        text_words.push_back(w);
        add_text("+16777217", 0);
        add_text("0.000", 0);
        while (text_words.size() < 1350) begin
            if ($urandom_range(0, 99) < 80)
                add_random_number();
            else
                add_noise();
        end
    endtask

    // Sender: idles at random except over a quiet stretch, and pauses once
    // until every pending result has come back.
    task automatic drive_text();
        int  idx;
        bit  paused;
        int  pause_at;
        idx = 0;
        paused = 0;
        pause_at = 700;
        while (idx < text_words.size()) begin
            @(posedge clk);
            if (in_valid && in_ready) begin
                parse_sb.note_char(in_word);
                idx++;
            end
            if (in_valid && !in_ready) begin
                // Hold the word until it is taken.
            end else if (idx >= text_words.size()) begin
                in_valid <= 1'b0;
            end else if (idx == pause_at && !paused) begin
                in_valid <= 1'b0;
                paused = 1;
                while (parse_sb.expected_words.size() != 0)
                    @(posedge clk);
            end else if ((idx < 400 || idx > 600) && $urandom_range(0, 99) < 19) begin
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_word <= text_words[idx];
            end
        end
        sending_done = 1;
    endtask

    // Receiver: random stalls, a quiet stretch, and one long hold-off that
    // lets the result register fill and back up the input.
    initial begin : result_sink
        int cycle;
        int hold;
        cycle = 0;
        hold = 0;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            cycle++;
            if (out_valid && out_ready)
                parse_sb.check_word(out_word);
            if (cycle == 2500)
                hold = 400;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else if (cycle > 1000 && cycle < 2000) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    initial begin
        parse_sb = new();
        sending_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        drive_text();
        while (parse_sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (parse_sb.errors == 0)
            $display("decimal_text_to_float_unit verification clean");
        else
            $display("decimal_text_to_float_unit verification failed");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20ms;
        $display("decimal_text_to_float_unit verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_ctrl.sv
hw/rtl/dtf_datapath.sv
hw/rtl/decimal_text_to_float_unit.sv
verif/decimal_text_to_float_unit_tb.sv
